>>> design/lsg_pkg.sv
// ----------------------------------------------------------------------------
// Line substring grep package
// Shared types and constants of the line substring grep unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lsg_pkg;

   localparam int PATTERN_MAX = 64;
   localparam int LINE_LIMIT  = 1024;

   localparam int PAT_LEN_W  = $clog2(PATTERN_MAX + 1);
   localparam int PAT_IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int LEN_W      = 10;
   localparam int LINE_W     = 16;
   localparam int BYTE_W     = 8;
   localparam int ROWS       = 1 << BYTE_W;

   localparam logic [LEN_W-1:0]  SCAN_MAX     = LEN_W'(LINE_LIMIT - 1);
   localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [FIFO_CNT_W-1:0] FIFO_THRESH = FIFO_CNT_W'(FIFO_DEPTH - 4);

   typedef enum logic [1:0] {
      FUNC_CLEAR   = 2'd0,
      FUNC_PATTERN = 2'd1,
      FUNC_TEXT    = 2'd2,
      FUNC_END     = 2'd3
   } func_type;

   typedef enum logic {
      KIND_REPORT  = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   typedef struct packed {
      func_type          func;
      logic [BYTE_W-1:0] data_byte;
   } req_type;

   typedef struct packed {
      kind_type          kind;
      logic [LINE_W-1:0] line_number;
      logic [LEN_W-1:0]  scanned_length;
      logic              truncated;
      logic              any_found;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

`default_nettype wire

>>> design/lsg_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lsg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> design/lsg_core.sv
// ----------------------------------------------------------------------------
// Line substring grep search core
// Holds a per-byte-value position mask table in RAM, runs the shift-and
// update for one beat per cycle and tracks the line and summary state.
// ----------------------------------------------------------------------------
`default_nettype none

module lsg_core import lsg_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_fire,
   input  wire req_type in_item,
   output      push_type push
);

   logic                   s1_valid_ff;
   req_type                s1_item_ff;
   logic [ROWS-1:0]        row_valid_ff;
   logic [ROWS-1:0]        row_valid_in;
   logic                   fwd_en_ff;
   logic [BYTE_W-1:0]      fwd_addr_ff;
   logic [PATTERN_MAX-1:0] fwd_data_ff;

   logic [PAT_LEN_W-1:0]   pat_len_ff, pat_len_in;
   logic [PATTERN_MAX-1:0] pmv_ff, pmv_in;
   logic                   matched_ff, matched_in;
   logic                   zero_seen_ff, zero_seen_in;
   logic [LEN_W-1:0]       count_ff, count_in;
   logic [LINE_W-1:0]      line_ff, line_in;
   logic                   found_ff, found_in;

   logic                   wr_en;
   logic [PATTERN_MAX-1:0] wr_data;
   logic [PATTERN_MAX-1:0] ram_rd;
   logic [PATTERN_MAX-1:0] row;
   logic [PATTERN_MAX-1:0] pmv_next;
   logic [PATTERN_MAX-1:0] pos_bit;
   logic [PAT_IDX_W-1:0]   top_idx;
   logic                   report;
   logic [LINE_W-1:0]      line_inc;
   rsp_type                rep_entry;
   rsp_type                sum_entry;
   logic [BYTE_W-1:0]      b;

   lsg_ram #(
      .WIDTH(PATTERN_MAX),
      .DEPTH(ROWS)
   ) u_mask_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(s1_item_ff.data_byte),
      .wr_data(wr_data),
      .rd_en  (in_fire),
      .rd_addr(in_item.data_byte),
      .rd_data(ram_rd)
   );

   assign b = s1_item_ff.data_byte;

   always_comb begin
      if (fwd_en_ff && (fwd_addr_ff == b)) begin
         row = fwd_data_ff;
      end else if (row_valid_ff[b]) begin
         row = ram_rd;
      end else begin
         row = '0;
      end
   end

   always_comb begin
      pos_bit  = '0;
      pos_bit[pat_len_ff[PAT_IDX_W-1:0]] = 1'b1;
      top_idx  = PAT_IDX_W'(pat_len_ff - 1'b1);
      pmv_next = {pmv_ff[PATTERN_MAX-2:0], 1'b1} & row;
      report   = (count_ff != '0) && (matched_ff || (pat_len_ff == '0));
      line_inc = (line_ff == '1) ? line_ff : line_ff + 1'b1;

      rep_entry                = '0;
      rep_entry.kind           = KIND_REPORT;
      rep_entry.line_number    = line_ff;
      rep_entry.scanned_length = count_ff;
      rep_entry.truncated      = (count_ff >= SCAN_MAX);
      rep_entry.last           = 1'b1;

      sum_entry           = '0;
      sum_entry.kind      = KIND_SUMMARY;
      sum_entry.any_found = found_ff || report;
      sum_entry.last      = 1'b1;
   end

   always_comb begin
      pat_len_in   = pat_len_ff;
      pmv_in       = pmv_ff;
      matched_in   = matched_ff;
      zero_seen_in = zero_seen_ff;
      count_in     = count_ff;
      line_in      = line_ff;
      found_in     = found_ff;
      row_valid_in = row_valid_ff;
      wr_en        = 1'b0;
      wr_data      = row | pos_bit;
      push         = '0;
      if (s1_valid_ff) begin
         case (s1_item_ff.func)
            FUNC_CLEAR: begin
               pat_len_in   = '0;
               pmv_in       = '0;
               matched_in   = 1'b0;
               zero_seen_in = 1'b0;
               count_in     = '0;
               line_in      = LINE_W'(1);
               found_in     = 1'b0;
               row_valid_in = '0;
            end
            FUNC_PATTERN: begin
               if ((b != '0) && (pat_len_ff < PAT_LEN_W'(PATTERN_MAX))) begin
                  wr_en           = 1'b1;
                  row_valid_in[b] = 1'b1;
                  pat_len_in      = pat_len_ff + 1'b1;
               end
            end
            FUNC_TEXT: begin
               if (b == NEWLINE_BYTE) begin
                  if (report) begin
                     push.count = 2'd1;
                     push.first = rep_entry;
                     found_in   = 1'b1;
                  end
                  line_in      = line_inc;
                  pmv_in       = '0;
                  matched_in   = 1'b0;
                  zero_seen_in = 1'b0;
                  count_in     = '0;
               end else if (count_ff < SCAN_MAX) begin
                  count_in = count_ff + 1'b1;
                  if (!zero_seen_ff) begin
                     if (b == '0) begin
                        zero_seen_in = 1'b1;
                     end else if (pat_len_ff != '0) begin
                        pmv_in = pmv_next;
                        if (pmv_next[top_idx]) begin
                           matched_in = 1'b1;
                        end
                     end
                  end
               end
            end
            FUNC_END: begin
               if (report) begin
                  push.count      = 2'd2;
                  push.first      = rep_entry;
                  push.first.last = 1'b0;
                  push.second     = sum_entry;
               end else begin
                  push.count = 2'd1;
                  push.first = sum_entry;
               end
               found_in     = 1'b0;
               line_in      = LINE_W'(1);
               pmv_in       = '0;
               matched_in   = 1'b0;
               zero_seen_in = 1'b0;
               count_in     = '0;
            end
            default: begin
               push = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= in_item;
      fwd_addr_ff <= b;
      fwd_data_ff <= wr_data;
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_en_ff    <= 1'b0;
         row_valid_ff <= '0;
         pat_len_ff   <= '0;
         pmv_ff       <= '0;
         matched_ff   <= 1'b0;
         zero_seen_ff <= 1'b0;
         count_ff     <= '0;
         line_ff      <= LINE_W'(1);
         found_ff     <= 1'b0;
      end else begin
         s1_valid_ff  <= in_fire;
         fwd_en_ff    <= wr_en;
         row_valid_ff <= row_valid_in;
         pat_len_ff   <= pat_len_in;
         pmv_ff       <= pmv_in;
         matched_ff   <= matched_in;
         zero_seen_ff <= zero_seen_in;
         count_ff     <= count_in;
         line_ff      <= line_in;
         found_ff     <= found_in;
      end
   end

endmodule

`default_nettype wire

>>> design/lsg_rsp_fifo.sv
// ----------------------------------------------------------------------------
// Line substring grep result queue
// Takes up to two results per cycle and hands them out one beat at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module lsg_rsp_fifo import lsg_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output      logic     almost_full,
   output      logic     out_valid,
   input  wire logic     out_stall,
   output      rsp_type  out_item
);

   rsp_type               entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff;
   logic [FIFO_PTR_W-1:0] wr_ptr_next;
   logic                  pop;

   assign wr_ptr_next = wr_ptr_ff + 1'b1;
   assign out_valid   = (count_ff != '0);
   assign out_item    = entry_ff[rd_ptr_ff];
   assign pop         = out_valid && !out_stall;
   assign almost_full = (count_ff > FIFO_THRESH);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.second;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(push.count);
         rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(pop);
         count_ff  <= count_ff + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
      end
   end

endmodule

`default_nettype wire

>>> design/line_substring_grep_unit.sv
// ----------------------------------------------------------------------------
// Line substring grep unit
// Finds lines of a byte stream that hold a fixed pattern and reports them.
//
//   Channel  Direction  Payload   Handshake
//   req      in         req_type  req_valid / req_stall
//   rsp      out        rsp_type  rsp_valid / rsp_stall
//
// One request beat is taken per cycle while requests are not stalled; its results
// pass through the registered read of the mask table RAM and the queue.
// A request gives zero, one or two result beats, held in an eight-entry queue.
// Requests are stalled while the queue holds more than four results.
// Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module line_substring_grep_unit import lsg_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_stall,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_stall,
   output      rsp_type rsp_data
);

   logic     in_fire;
   logic     almost_full;
   push_type push;

   assign req_stall = almost_full;
   assign in_fire   = req_valid && !almost_full;

   lsg_core u_core (
      .clock  (clock),
      .reset  (reset),
      .in_fire(in_fire),
      .in_item(req_data),
      .push   (push)
   );

   lsg_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .almost_full(almost_full),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_item   (rsp_data)
   );

endmodule

`default_nettype wire

>>> bench/tb_line_substring_grep_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line substring grep unit testbench
// Drives pattern, text and end-of-text beats into the unit. A directed table
// comes first, then a receiver hold-off, a long truncated line and random
// sessions. Every result beat is checked field by field against a shift-and
// line search kept in step with the accepted requests.
// ----------------------------------------------------------------------------

module tb_line_substring_grep_unit;
   import lsg_pkg::*;

   localparam int HOLD_CYCLES  = 120;
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 130;
   localparam int TAIL_CYCLES  = 8;
   localparam int LINE_NO_MAX  = (1 << LINE_W) - 1;

   typedef struct packed {
      req_type req;
      bit      typed;
      rsp_type want;
   } step_row_type;

   localparam rsp_type NO_WANT = '0;

   // Typed rows carry the single result that they must give.
   localparam step_row_type DIRECTED [25] = '{
      '{'{FUNC_END,     8'h00}, 1'b1, '{KIND_SUMMARY, 16'd0, 10'd0, 1'b0, 1'b0, 1'b1}},
      '{'{FUNC_TEXT,    8'hFF}, 1'b0, NO_WANT},
      '{'{FUNC_TEXT,    8'h0A}, 1'b1, '{KIND_REPORT, 16'd1, 10'd1, 1'b0, 1'b0, 1'b1}},
      '{'{FUNC_TEXT,    8'h0A}, 1'b0, NO_WANT},
      '{'{FUNC_TEXT,    8'h00}, 1'b0, NO_WANT},
      '{'{FUNC_END,     8'h00}, 1'b0, NO_WANT},
      '{'{FUNC_PATTERN, 8'h00}, 1'b0, NO_WANT},
      '{'{FUNC_PATTERN, 8'h61}, 1'b0, NO_WANT},
      '{'{FUNC_PATTERN, 8'h62}, 1'b0, NO_WANT},
      '{'{FUNC_TEXT,    8'h61}, 1'b0, NO_WANT},
      '{'{FUNC_TEXT,    8'h00}, 1'b0, NO_WANT},
      '{'{FUNC_TEXT,    8'h62}, 1'b0, NO_WANT},
      '{'{FUNC_TEXT,    8'h0A}, 1'b0, NO_WANT},
      '{'{FUNC_TEXT,    8'h61}, 1'b0, NO_WANT},
      '{'{FUNC_PATTERN, 8'h63}, 1'b0, NO_WANT},
      '{'{FUNC_TEXT,    8'h62}, 1'b0, NO_WANT},
      '{'{FUNC_TEXT,    8'h63}, 1'b0, NO_WANT},
      '{'{FUNC_TEXT,    8'h0A}, 1'b0, NO_WANT},
      '{'{FUNC_PATTERN, 8'hFF}, 1'b0, NO_WANT},
      '{'{FUNC_TEXT,    8'h55}, 1'b0, NO_WANT},
      '{'{FUNC_CLEAR,   8'hAA}, 1'b0, NO_WANT},
      '{'{FUNC_END,     8'h00}, 1'b1, '{KIND_SUMMARY, 16'd0, 10'd0, 1'b0, 1'b0, 1'b1}},
      '{'{FUNC_PATTERN, 8'hFF}, 1'b0, NO_WANT},
      '{'{FUNC_TEXT,    8'hFF}, 1'b0, NO_WANT},
      '{'{FUNC_END,     8'hFF}, 1'b0, NO_WANT}
   };

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rsp_type report_q [$];
   bit      idle_on   = 1'b1;
   int      hold_asks = 0;
   int      items_sent = 0;
   int      reports_seen = 0;
   int      summaries_seen = 0;
   int      errors = 0;

   logic [BYTE_W-1:0]      pat_mem [PATTERN_MAX];
   int                     pat_len;
   logic [PATTERN_MAX-1:0] hit_vec;
   bit                     line_hit;
   bit                     nul_seen;
   bit                     any_matched;
   int                     line_bytes;
   int                     line_no;

   line_substring_grep_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void reset_line();
      hit_vec    = '0;
      line_hit   = 1'b0;
      nul_seen   = 1'b0;
      line_bytes = 0;
   endfunction

   function automatic void reset_grep();
      pat_len     = 0;
      reset_line();
      line_no     = 1;
      any_matched = 1'b0;
   endfunction

   function automatic void close_line(bit last_bit);
      rsp_type r = '0;
      if (line_bytes > 0 && (line_hit || pat_len == 0)) begin
         r.kind           = KIND_REPORT;
         r.line_number    = LINE_W'(line_no);
         r.scanned_length = LEN_W'(line_bytes);
         r.truncated      = (line_bytes >= LINE_LIMIT - 1);
         r.last           = last_bit;
         report_q.push_back(r);
         any_matched = 1'b1;
      end
      if (line_no < LINE_NO_MAX) line_no++;
      reset_line();
   endfunction

   function automatic void scan_byte(logic [BYTE_W-1:0] b);
      if (pat_len == 0) return;
      for (int j = pat_len - 1; j > 0; j--) begin
         hit_vec[j] = hit_vec[j-1] && (pat_mem[j] == b);
      end
      hit_vec[0] = (pat_mem[0] == b);
      if (hit_vec[pat_len-1]) line_hit = 1'b1;
   endfunction

   function automatic void grep_step(req_type r);
      rsp_type s = '0;
      case (r.func)
         FUNC_CLEAR: reset_grep();
         FUNC_PATTERN: begin
            if (r.data_byte != 8'h00 && pat_len < PATTERN_MAX) begin
               pat_mem[pat_len] = r.data_byte;
               pat_len++;
            end
         end
         FUNC_TEXT: begin
            if (r.data_byte == NEWLINE_BYTE) begin
               close_line(1'b1);
            end else if (line_bytes < LINE_LIMIT - 1) begin
               line_bytes++;
               if (!nul_seen) begin
                  if (r.data_byte == 8'h00) nul_seen = 1'b1;
                  else scan_byte(r.data_byte);
               end
            end
         end
         default: begin
            close_line(1'b0);
            s.kind      = KIND_SUMMARY;
            s.any_found = any_matched;
            s.last      = 1'b1;
            report_q.push_back(s);
            any_matched = 1'b0;
            line_no     = 1;
         end
      endcase
   endfunction

   task automatic send_beat(func_type f, logic [BYTE_W-1:0] b, bit typed = 1'b0,
                            rsp_type want = '0);
      req_type r;
      int      gap;
      int      depth;
      r.func      = f;
      r.data_byte = b;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      if (!(f == FUNC_PATTERN && (b == 8'h00 || pat_len >= PATTERN_MAX))) items_sent++;
      depth = report_q.size();
      grep_step(r);
      if (typed) begin
         while (report_q.size() > depth) void'(report_q.pop_back());
         report_q.push_back(want);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (report_q.size() != 0) @(posedge clock);
   endtask

   task automatic long_line(int n_len, int hit_at);
      logic [BYTE_W-1:0] body [$];
      repeat (n_len) body.push_back(8'h78 + 8'($urandom_range(0, 1)));
      if (hit_at >= 0) begin
         for (int k = 0; k < 3; k++) body[hit_at + k] = 8'h61 + 8'(k);
      end
      foreach (body[k]) send_beat(FUNC_TEXT, body[k]);
      send_beat(FUNC_TEXT, NEWLINE_BYTE);
   endtask

   task automatic random_session();
      logic [BYTE_W-1:0] pat_q [$];
      logic [BYTE_W-1:0] line_q [$];
      logic [BYTE_W-1:0] b;
      int                n_pat;
      int                n_lines;
      int                n_len;
      int                pick;
      if ($urandom_range(0, 9) == 0) begin
         send_beat(func_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         return;
      end
      if ($urandom_range(0, 9) < 7) begin
         send_beat(FUNC_CLEAR, 8'($urandom_range(0, 255)));
         pick  = $urandom_range(0, 19);
         n_pat = (pick < 14) ? $urandom_range(0, 4) :
                 (pick < 18) ? $urandom_range(5, 16) : $urandom_range(60, 70);
         repeat (n_pat) begin
            pick = $urandom_range(0, 19);
            b = (pick < 17) ? 8'h61 + 8'($urandom_range(0, 2)) :
                (pick < 19) ? 8'($urandom_range(1, 255)) : 8'h00;
            if (b != 8'h00) pat_q.push_back(b);
            send_beat(FUNC_PATTERN, b);
         end
      end
      n_lines = $urandom_range(1, 6);
      for (int i = 0; i < n_lines; i++) begin
         line_q.delete();
         n_len = ($urandom_range(0, 6) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
         repeat (n_len) begin
            pick = $urandom_range(0, 99);
            b = (pick < 75) ? 8'h61 + 8'($urandom_range(0, 3)) :
                (pick < 80) ? 8'h00 : 8'($urandom_range(0, 255));
            line_q.push_back(b);
         end
         if (pat_q.size() > 0 && $urandom_range(0, 9) < 4) begin
            pick = $urandom_range(0, line_q.size());
            foreach (pat_q[k]) line_q.insert(pick + k, pat_q[k]);
         end
         foreach (line_q[k]) begin
            if ($urandom_range(0, 49) == 0) begin
               send_beat(FUNC_PATTERN, 8'h61 + 8'($urandom_range(0, 2)));
            end
            send_beat(FUNC_TEXT, line_q[k]);
         end
         if (i == n_lines - 1 && $urandom_range(0, 4) != 0) begin
            send_beat(FUNC_END, 8'($urandom_range(0, 255)));
         end else begin
            send_beat(FUNC_TEXT, NEWLINE_BYTE);
         end
      end
   endtask

   function automatic void flag_mismatch(string what, rsp_type want, rsp_type got);
      errors++;
      if (errors <= 10) begin
         $display("%s: expected kind=%0d line=%0d len=%0d trunc=%0d any=%0d last=%0d,",
                  what, want.kind, want.line_number, want.scanned_length, want.truncated,
                  want.any_found, want.last);
         $display("   got kind=%0d line=%0d len=%0d trunc=%0d any=%0d last=%0d",
                  got.kind, got.line_number, got.scanned_length, got.truncated,
                  got.any_found, got.last);
      end
   endfunction

   initial begin : rsp_side
      int burst;
      int hold;
      int seen;
      burst = 0;
      hold  = 0;
      seen  = 0;
      forever begin
         @(negedge clock);
         if (hold_asks != seen) begin
            seen = hold_asks;
            hold = HOLD_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else if (burst > 0) begin
            burst--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(0, 5);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : rsp_check
      rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (rsp_data.kind == KIND_SUMMARY) summaries_seen++;
            else reports_seen++;
            if (report_q.size() == 0) begin
               flag_mismatch("unexpected beat", '0, rsp_data);
            end else begin
               want = report_q.pop_front();
               if (rsp_data.kind !== want.kind
                   || rsp_data.line_number !== want.line_number
                   || rsp_data.scanned_length !== want.scanned_length
                   || rsp_data.truncated !== want.truncated
                   || rsp_data.any_found !== want.any_found
                   || rsp_data.last !== want.last) begin
                  flag_mismatch("wrong beat", want, rsp_data);
               end
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("Watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("line_substring_grep_unit: mismatch");
      $finish;
   end

   initial begin : stimulus
      int start;
      reset_grep();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         send_beat(DIRECTED[i].req.func, DIRECTED[i].req.data_byte,
                   DIRECTED[i].typed, DIRECTED[i].want);
      end
      drain();

      // The receiver holds off while short matching lines keep coming, so
      // the result queue fills and the request side is stalled.
      send_beat(FUNC_CLEAR, 8'h00);
      hold_asks++;
      repeat (30) begin
         send_beat(FUNC_TEXT, 8'h7A);
         send_beat(FUNC_TEXT, NEWLINE_BYTE);
      end
      drain();

      send_beat(FUNC_CLEAR, 8'h00);
      send_beat(FUNC_PATTERN, 8'h61);
      send_beat(FUNC_PATTERN, 8'h62);
      send_beat(FUNC_PATTERN, 8'h63);
      long_line(1024, 1019);
      send_beat(FUNC_END, 8'h00);
      drain();

      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         if (items_sent - start < RANDOM_ITEMS * 3 / 4) idle_on = ($urandom_range(0, 3) != 0);
         else idle_on = 1'b0;
         random_session();
      end
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (report_q.size() != 0) begin
         $display("%0d expected beats never arrived", report_q.size());
         errors += report_q.size();
      end
      $display("Sent %0d request beats; checked %0d line reports and %0d summaries.",
               items_sent, reports_seen, summaries_seen);
      $display("Included a long truncated line, full patterns, zero bytes "
               , "and a long receiver hold-off.");
      if (errors == 0) $display("line_substring_grep_unit: match");
      else $display("line_substring_grep_unit: mismatch");
      $finish;
   end

endmodule

>>> files.f
design/lsg_pkg.sv
design/lsg_ram.sv
design/lsg_core.sv
design/lsg_rsp_fifo.sv
design/line_substring_grep_unit.sv
bench/tb_line_substring_grep_unit.sv
